### rtl/core/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// shared types and constants for the identifier sub-word splitter
// ----------------------------------------------------------------------------
package iss_pkg;

    // default sizing
    localparam int C_MAX_PARTS = 16;
    localparam int C_MAX_LEN   = 256;

    // field widths of one stored part: start and length as they leave the block
    localparam int C_START_W = 8;
    localparam int C_LEN_W   = 9;
    localparam int C_ENTRY_W = C_START_W + C_LEN_W;

    // character codes
    localparam logic [6:0] C_CH_UNDERSCORE = 7'h5F;
    localparam logic [6:0] C_CH_UPPER_A    = 7'h41;
    localparam logic [6:0] C_CH_UPPER_Z    = 7'h5A;
    localparam logic [6:0] C_CH_LOWER_A    = 7'h61;
    localparam logic [6:0] C_CH_LOWER_Z    = 7'h7A;
    localparam logic [6:0] C_CH_DIGIT_0    = 7'h30;
    localparam logic [6:0] C_CH_DIGIT_9    = 7'h39;

    typedef struct packed {
        logic [6:0] char_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [C_START_W-1:0] token_start;
        logic [C_LEN_W-1:0]   token_length;
        logic                 is_whole;
        logic                 overflowed;
        logic                 last_of_run;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_TAIL_CUT,
        ST_TAIL_ADD,
        ST_WHOLE,
        ST_PARTS
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic tail_cut;
        logic tail_add;
        logic emit_whole;
        logic emit_part;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic saw;
        logic slot_free;
        logic part_empty;
        logic part_final;
    } t_status;

endpackage

### rtl/core/iss_ram.sv
// ----------------------------------------------------------------------------
// iss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module iss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// sequencer: collect bytes, close the last part, then drain tokens
// ----------------------------------------------------------------------------
module iss_ctrl
    import iss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (i_in_valid && i_status.in_last) begin
                    n_state = ST_TAIL_CUT;
                end
            end
            ST_TAIL_CUT: n_state = ST_TAIL_ADD;
            ST_TAIL_ADD: n_state = ST_WHOLE;
            ST_WHOLE: begin
                if (!i_status.saw) begin
                    n_state = ST_COLLECT;
                end else if (i_status.slot_free) begin
                    n_state = i_status.part_empty ? ST_COLLECT : ST_PARTS;
                end
            end
            ST_PARTS: begin
                if (i_status.slot_free && i_status.part_final) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_COLLECT: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_TAIL_CUT: o_cmd.tail_cut = 1'b1;
            ST_TAIL_ADD: o_cmd.tail_add = 1'b1;
            ST_WHOLE: begin
                if (!i_status.saw) begin
                    o_cmd.clear = 1'b1;
                end else if (i_status.slot_free) begin
                    o_cmd.emit_whole = 1'b1;
                    o_cmd.clear      = i_status.part_empty;
                end
            end
            ST_PARTS: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_part = 1'b1;
                    o_cmd.clear     = i_status.part_final;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/iss_dp.sv
// ----------------------------------------------------------------------------
// iss_dp
// datapath: boundary detection, part store and output register
// ----------------------------------------------------------------------------
module iss_dp
    import iss_pkg::*;
#(
    parameter int MAX_PARTS = C_MAX_PARTS,
    parameter int MAX_LEN   = C_MAX_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int IW = $clog2(MAX_PARTS);
    localparam int EW = PW + C_LEN_W;
    localparam logic [PW-1:0] LEN_LIMIT  = PW'(MAX_LEN);
    localparam logic [CW-1:0] PART_LIMIT = CW'(MAX_PARTS);

    function automatic logic ch_upper(input logic [6:0] c);
        ch_upper = (c >= C_CH_UPPER_A) && (c <= C_CH_UPPER_Z);
    endfunction

    function automatic logic ch_lower(input logic [6:0] c);
        ch_lower = (c >= C_CH_LOWER_A) && (c <= C_CH_LOWER_Z);
    endfunction

    function automatic logic ch_digit(input logic [6:0] c);
        ch_digit = (c >= C_CH_DIGIT_0) && (c <= C_CH_DIGIT_9);
    endfunction

    logic [PW-1:0] r_pos,   n_pos;
    logic [PW-1:0] r_begin, n_begin;
    logic [6:0]    r_prev,  n_prev;
    logic [6:0]    r_pprev, n_pprev;
    logic [CW-1:0] r_count, n_count;
    logic          r_saw,   n_saw;
    logic          r_ovf,   n_ovf;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out_word,  n_out_word;

    logic [PW-1:0]        q;
    logic                 has_room;
    logic                 check_en;
    logic                 prev_us;
    logic                 cut;
    logic                 add_req;
    logic [PW-1:0]        add_start;
    logic [PW-1:0]        add_len;
    logic [EW-1:0]        ext_start;
    logic [EW-1:0]        ext_len;
    logic [EW-1:0]        ext_pos;
    logic                 count_room;
    logic                 wr_en;
    logic [C_ENTRY_W-1:0] wr_data;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [C_ENTRY_W-1:0] rd_data;
    logic                 slot_free;
    logic                 part_final;

    iss_ram #(
        .WIDTH (C_ENTRY_W),
        .DEPTH (MAX_PARTS)
    ) u_part_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // boundary at the position of the previous byte
    always_comb begin
        q        = r_pos - PW'(1);
        has_room = r_pos < LEN_LIMIT;
        check_en = (r_pos != '0) && ((i_cmd.take && has_room) || i_cmd.tail_cut);
        prev_us  = r_prev == C_CH_UNDERSCORE;
        cut      = prev_us
                 || ((q > r_begin)
                     && ((ch_upper(r_prev) && (ch_lower(r_pprev) || ch_digit(r_pprev)))
                         || (ch_upper(r_pprev) && ch_upper(r_prev) && i_cmd.take
                             && ch_lower(i_in_word.char_byte))));
    end

    // part append
    always_comb begin
        add_req   = 1'b0;
        add_start = r_begin;
        add_len   = q - r_begin;
        if (check_en && cut && (q > r_begin)) begin
            add_req = 1'b1;
        end
        if (i_cmd.tail_add && (r_pos > r_begin) && (r_begin != '0)) begin
            add_req = 1'b1;
            add_len = r_pos - r_begin;
        end
        count_room = r_count < PART_LIMIT;
        wr_en      = add_req && count_room;
        ext_start  = EW'(add_start);
        ext_len    = EW'(add_len);
        ext_pos    = EW'(r_pos);
        wr_data    = {ext_start[C_START_W-1:0], ext_len[C_LEN_W-1:0]};
    end

    assign slot_free  = !r_out_valid || i_out_ready;
    assign part_final = (CW'(r_rd_idx) + CW'(1)) == r_count;

    always_comb begin
        n_pos       = r_pos;
        n_begin     = r_begin;
        n_prev      = r_prev;
        n_pprev     = r_pprev;
        n_count     = r_count;
        n_saw       = r_saw;
        n_ovf       = r_ovf;
        n_rd_idx    = r_rd_idx;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = r_rd_idx + IW'(1);

        if (check_en && cut) begin
            n_begin = prev_us ? r_pos : q;
        end
        if (i_cmd.take) begin
            if (has_room) begin
                if (i_in_word.char_byte != C_CH_UNDERSCORE) begin
                    n_saw = 1'b1;
                end
                n_pprev = r_prev;
                n_prev  = i_in_word.char_byte;
                n_pos   = r_pos + PW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (add_req) begin
            if (count_room) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.emit_whole) begin
            n_out_valid              = 1'b1;
            n_out_word.token_start   = '0;
            n_out_word.token_length  = ext_pos[C_LEN_W-1:0];
            n_out_word.is_whole      = 1'b1;
            n_out_word.overflowed    = r_ovf;
            n_out_word.last_of_run   = r_count == '0;
            n_rd_idx                 = '0;
            rd_en                    = 1'b1;
            rd_addr                  = '0;
        end
        if (i_cmd.emit_part) begin
            n_out_valid              = 1'b1;
            n_out_word.token_start   = rd_data[C_ENTRY_W-1:C_LEN_W];
            n_out_word.token_length  = rd_data[C_LEN_W-1:0];
            n_out_word.is_whole      = 1'b0;
            n_out_word.overflowed    = r_ovf;
            n_out_word.last_of_run   = part_final;
            n_rd_idx                 = r_rd_idx + IW'(1);
            rd_en                    = !part_final;
        end

        if (i_cmd.clear) begin
            n_pos   = '0;
            n_begin = '0;
            n_prev  = '0;
            n_pprev = '0;
            n_count = '0;
            n_saw   = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_begin     <= '0;
            r_prev      <= '0;
            r_pprev     <= '0;
            r_count     <= '0;
            r_saw       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_begin     <= n_begin;
            r_prev      <= n_prev;
            r_pprev     <= n_pprev;
            r_count     <= n_count;
            r_saw       <= n_saw;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_out_word <= n_out_word;
    end

    always_comb begin
        o_status.in_last    = i_in_word.is_last;
        o_status.saw        = r_saw;
        o_status.slot_free  = slot_free;
        o_status.part_empty = r_count == '0;
        o_status.part_final = part_final;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### rtl/core/identifier_subword_splitter.sv
// ----------------------------------------------------------------------------
// identifier_subword_splitter
// splits an identifier into its whole token and its camel / snake sub-words
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready   | t_in_word: byte, last flag
//  out      | output    | o_out_valid / i_out_ready | t_out_word: one token
//
//  a byte that is not the last keeps the sequencer collecting; the input is taken in the
//  collect state only
//  after the last byte the tail-cut and tail-add states close the final part, then the
//  whole token and each stored part leave one per cycle while the output is not stalled,
//  paced by the output register and the registered read port of the part ram
//  an identifier of underscores only leaves no token; it clears in the whole state
//  reset is synchronous, active low; the part ram needs no clearing pass
//  a stalled output holds the drain, no byte is taken until it completes
//
module identifier_subword_splitter
    import iss_pkg::*;
#(
    parameter int MAX_PARTS = C_MAX_PARTS,
    parameter int MAX_LEN   = C_MAX_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: byte intake, tail close-out, token drain
    iss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: boundary rules, part ram, output register
    iss_dp #(
        .MAX_PARTS (MAX_PARTS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
